>>> rtl/assert_macros.svh
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ksjt_pkg.sv
`default_nettype none

package ksjt_pkg;

  localparam int MAX_NODES_DEF = 1024;
  localparam int LEVELS_DEF    = 11;

  localparam int NODE_W    = 10;
  localparam int ENTRY_W   = 11;
  localparam int STEP_W    = 16;
  localparam int STATUS_W  = 2;
  localparam int CMP_W     = STEP_W + 1;
  localparam int IDX_MAX_W = 16;

  localparam logic [ENTRY_W-1:0] NO_NODE = '1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_BUILT = 2'd1,
    STATUS_RANGE     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_B0_RD,
    ST_B0_WR,
    ST_BL_RD1,
    ST_BL_RD2,
    ST_BL_WR,
    ST_Q_ISSUE,
    ST_Q_WAIT
  } state_e;

endpackage

`default_nettype wire

>>> rtl/ksjt_ram.sv
`default_nettype none

module ksjt_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/ksjt_agen.sv
`default_nettype none

module ksjt_agen #(
  parameter int MAX_NODES = ksjt_pkg::MAX_NODES_DEF,
  parameter int LEVELS    = ksjt_pkg::LEVELS_DEF
) (
  input  wire logic [$clog2(LEVELS)-1:0]             level_i,
  input  wire logic [$clog2(MAX_NODES)-1:0]          node_i,
  output logic      [$clog2(MAX_NODES*LEVELS)-1:0]   addr_o
);

  localparam int ADDR_W = $clog2(MAX_NODES * LEVELS);

  // level-major layout
  assign addr_o = ADDR_W'(ADDR_W'(level_i) * ADDR_W'(MAX_NODES)) + ADDR_W'(node_i);

endmodule

`default_nettype wire

>>> rtl/kth_successor_jump_table.sv
`default_nettype none

// k-th successor engine over a successor forest, binary lifting.
// command channel: an item is taken at a clock edge with start_i high and
// busy_o low. operation_i selects load or query.
// loads arrive in node order and each writes one level-0 entry; the
// load with last_load_i high then builds the doubling table: level 0 is read
// and cleaned up node by node, then each further level is built node by node
// from the entry one level down and the entry of that successor, all through
// the single table memory port. a load after a finished build starts a new set.
// queries: rejected or zero-step queries answer in the cycle after they are
// taken; others walk the table level by level from level 0: for each set bit
// of step_count_i the entry of the current node at that level is read and
// the walk moves to it. busy_o stays high while a build or a walk runs.
// each result shows on ancestor_o / status_o for one cycle with done_o high;
// the receiver cannot stall, and the next item may be taken in that cycle.
// reset clears the set and the built flag; table contents are left as is.
module kth_successor_jump_table #(
  parameter int MAX_NODES = ksjt_pkg::MAX_NODES_DEF,
  parameter int LEVELS    = ksjt_pkg::LEVELS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic                                operation_i,
  input  wire logic        [ksjt_pkg::NODE_W-1:0]  node_i,
  input  wire logic signed [ksjt_pkg::ENTRY_W-1:0] successor_i,
  input  wire logic                                last_load_i,
  input  wire logic        [ksjt_pkg::STEP_W-1:0]  step_count_i,
  output logic                                     done_o,
  output logic signed      [ksjt_pkg::ENTRY_W-1:0] ancestor_o,
  output logic             [ksjt_pkg::STATUS_W-1:0] status_o
);

  localparam int NODE_IW = $clog2(MAX_NODES);
  localparam int CNT_W   = $clog2(MAX_NODES + 1);
  localparam int LVL_W   = $clog2(LEVELS);
  localparam int ADDR_W  = $clog2(MAX_NODES * LEVELS);
  localparam int ENTRY_W = ksjt_pkg::ENTRY_W;
  localparam int CMP_W   = ksjt_pkg::CMP_W;
  localparam int IDX_W   = ksjt_pkg::IDX_MAX_W;

  function automatic logic [NODE_IW-1:0] to_idx(input logic [ENTRY_W-1:0] e);
    logic [IDX_W-1:0] w;
    w = IDX_W'(e[ENTRY_W-2:0]);
    return w[NODE_IW-1:0];
  endfunction

  ksjt_pkg::state_e  state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               ready_q, ready_d;
  logic [NODE_IW-1:0] i_q, i_d;
  logic [LVL_W-1:0]   bp_q, bp_d;
  logic [LVL_W-1:0]   qp_q, qp_d;
  logic [LEVELS-1:0]  k_q, k_d;
  logic [ENTRY_W-1:0] at_q, at_d;
  logic               done_q, done_d;
  logic [ENTRY_W-1:0] anc_q, anc_d;
  ksjt_pkg::status_e  status_q, status_d;

  logic               ram_we;
  logic [LVL_W-1:0]   lvl_sel;
  logic [NODE_IW-1:0] idx_sel;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [ADDR_W-1:0]  ram_addr;

  logic               accept;
  logic [CNT_W-1:0]   ld_eff;
  logic               ld_room;
  logic [CNT_W-1:0]   ld_count;
  logic               q_range;
  logic               q_k_big;
  logic               q_zero;
  logic               q_walk;
  logic [31:0]        step_ext;
  logic               rd_neg;
  logic               s_bad;
  logic               last_i;
  logic               last_lvl;

  assign busy_o   = (state_q != ksjt_pkg::ST_IDLE);
  assign accept   = start_i && !busy_o;

  assign ld_eff   = ready_q ? '0 : count_q;
  assign ld_room  = (ld_eff < CNT_W'(MAX_NODES));
  assign ld_count = ld_eff + CNT_W'(ld_room);

  assign step_ext = 32'(step_count_i);
  assign q_range  = (CMP_W'(node_i) >= CMP_W'(count_q));
  assign q_k_big  = (CMP_W'(step_count_i) > CMP_W'(count_q)) || ((step_ext >> LEVELS) != '0);
  assign q_zero   = (step_count_i == '0);
  assign q_walk   = ready_q && !q_range && !q_k_big && !q_zero;

  assign rd_neg   = ram_rdata[ENTRY_W-1];
  assign s_bad    = rd_neg || (CMP_W'(ram_rdata[ENTRY_W-2:0]) >= CMP_W'(count_q));
  assign last_i   = (CMP_W'(i_q) + CMP_W'(1) == CMP_W'(count_q));
  assign last_lvl = (bp_q == LVL_W'(LEVELS - 1));

  ksjt_agen #(
    .MAX_NODES (MAX_NODES),
    .LEVELS    (LEVELS)
  ) u_agen (
    .level_i (lvl_sel),
    .node_i  (idx_sel),
    .addr_o  (ram_addr)
  );

  ksjt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_NODES * LEVELS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ksjt_pkg::ST_IDLE: begin
        if (accept) begin
          if (operation_i == ksjt_pkg::OP_QUERY) begin
            if (q_walk) begin
              state_d = ksjt_pkg::ST_Q_ISSUE;
            end
          end else if (last_load_i) begin
            state_d = ksjt_pkg::ST_B0_RD;
          end
        end
      end
      ksjt_pkg::ST_B0_RD: state_d = ksjt_pkg::ST_B0_WR;
      ksjt_pkg::ST_B0_WR: begin
        state_d = last_i ? ksjt_pkg::ST_BL_RD1 : ksjt_pkg::ST_B0_RD;
      end
      ksjt_pkg::ST_BL_RD1: state_d = ksjt_pkg::ST_BL_RD2;
      ksjt_pkg::ST_BL_RD2: begin
        if (!rd_neg) begin
          state_d = ksjt_pkg::ST_BL_WR;
        end else if (last_i && last_lvl) begin
          state_d = ksjt_pkg::ST_IDLE;
        end else begin
          state_d = ksjt_pkg::ST_BL_RD1;
        end
      end
      ksjt_pkg::ST_BL_WR: begin
        state_d = (last_i && last_lvl) ? ksjt_pkg::ST_IDLE : ksjt_pkg::ST_BL_RD1;
      end
      ksjt_pkg::ST_Q_ISSUE: begin
        if (k_q == '0) begin
          state_d = ksjt_pkg::ST_IDLE;
        end else if (k_q[0]) begin
          state_d = ksjt_pkg::ST_Q_WAIT;
        end
      end
      ksjt_pkg::ST_Q_WAIT: begin
        state_d = rd_neg ? ksjt_pkg::ST_IDLE : ksjt_pkg::ST_Q_ISSUE;
      end
      default: state_d = ksjt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    lvl_sel   = '0;
    idx_sel   = i_q;
    ram_wdata = ram_rdata;
    count_d   = count_q;
    ready_d   = ready_q;
    i_d       = i_q;
    bp_d      = bp_q;
    qp_d      = qp_q;
    k_d       = k_q;
    at_d      = at_q;
    done_d    = 1'b0;
    anc_d     = anc_q;
    status_d  = status_q;
    case (state_q)
      ksjt_pkg::ST_IDLE: begin
        if (accept) begin
          if (operation_i == ksjt_pkg::OP_LOAD) begin
            ram_we    = ld_room;
            idx_sel   = ld_eff[NODE_IW-1:0];
            ram_wdata = successor_i;
            count_d   = ld_count;
            ready_d   = 1'b0;
            i_d       = '0;
            bp_d      = LVL_W'(1);
          end else if (!ready_q) begin
            done_d   = 1'b1;
            anc_d    = ksjt_pkg::NO_NODE;
            status_d = ksjt_pkg::STATUS_NOT_BUILT;
          end else if (q_range) begin
            done_d   = 1'b1;
            anc_d    = ksjt_pkg::NO_NODE;
            status_d = ksjt_pkg::STATUS_RANGE;
          end else if (q_k_big) begin
            done_d   = 1'b1;
            anc_d    = ksjt_pkg::NO_NODE;
            status_d = ksjt_pkg::STATUS_OK;
          end else if (q_zero) begin
            done_d   = 1'b1;
            anc_d    = ENTRY_W'(node_i);
            status_d = ksjt_pkg::STATUS_OK;
          end else begin
            at_d = ENTRY_W'(node_i);
            k_d  = step_ext[LEVELS-1:0];
            qp_d = '0;
          end
        end
      end
      ksjt_pkg::ST_B0_RD: begin
        idx_sel = i_q;
      end
      ksjt_pkg::ST_B0_WR: begin
        // level 0 cleanup: bad successors become no node
        ram_we    = 1'b1;
        ram_wdata = s_bad ? ksjt_pkg::NO_NODE : ram_rdata;
        i_d       = last_i ? '0 : i_q + NODE_IW'(1);
      end
      ksjt_pkg::ST_BL_RD1: begin
        lvl_sel = bp_q - LVL_W'(1);
      end
      ksjt_pkg::ST_BL_RD2: begin
        if (rd_neg) begin
          ram_we    = 1'b1;
          lvl_sel   = bp_q;
          ram_wdata = ksjt_pkg::NO_NODE;
          if (last_i) begin
            i_d = '0;
            if (last_lvl) begin
              ready_d = 1'b1;
            end else begin
              bp_d = bp_q + LVL_W'(1);
            end
          end else begin
            i_d = i_q + NODE_IW'(1);
          end
        end else begin
          lvl_sel = bp_q - LVL_W'(1);
          idx_sel = to_idx(ram_rdata);
        end
      end
      ksjt_pkg::ST_BL_WR: begin
        ram_we    = 1'b1;
        lvl_sel   = bp_q;
        ram_wdata = ram_rdata;
        if (last_i) begin
          i_d = '0;
          if (last_lvl) begin
            ready_d = 1'b1;
          end else begin
            bp_d = bp_q + LVL_W'(1);
          end
        end else begin
          i_d = i_q + NODE_IW'(1);
        end
      end
      ksjt_pkg::ST_Q_ISSUE: begin
        lvl_sel = qp_q;
        idx_sel = to_idx(at_q);
        if (k_q == '0) begin
          done_d   = 1'b1;
          anc_d    = at_q;
          status_d = ksjt_pkg::STATUS_OK;
        end else if (!k_q[0]) begin
          k_d  = k_q >> 1;
          qp_d = qp_q + LVL_W'(1);
        end
      end
      ksjt_pkg::ST_Q_WAIT: begin
        at_d = ram_rdata;
        k_d  = k_q >> 1;
        qp_d = qp_q + LVL_W'(1);
        if (rd_neg) begin
          done_d   = 1'b1;
          anc_d    = ksjt_pkg::NO_NODE;
          status_d = ksjt_pkg::STATUS_OK;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ksjt_pkg::ST_IDLE;
      count_q <= '0;
      ready_q <= 1'b0;
      done_q  <= 1'b0;
      i_q     <= '0;
      bp_q    <= '0;
      qp_q    <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ready_q <= ready_d;
      done_q  <= done_d;
      i_q     <= i_d;
      bp_q    <= bp_d;
      qp_q    <= qp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q      <= k_d;
    at_q     <= at_d;
    anc_q    <= anc_d;
    status_q <= status_d;
  end

  assign done_o     = done_q;
  assign ancestor_o = anc_q;
  assign status_o   = status_q;

endmodule

`default_nettype wire

>>> rtl/ksjt_checker.sv
`default_nettype none

`include "assert_macros.svh"

module ksjt_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                start_i,
  input wire logic                                busy_o,
  input wire logic                                operation_i,
  input wire logic        [ksjt_pkg::NODE_W-1:0]  node_i,
  input wire logic        [ksjt_pkg::STEP_W-1:0]  step_count_i,
  input wire logic                                done_o,
  input wire logic signed [ksjt_pkg::ENTRY_W-1:0] ancestor_o,
  input wire logic        [ksjt_pkg::STATUS_W-1:0] status_o
);

  logic                          take_query;
  logic                          take_load;
  logic [ksjt_pkg::ENTRY_W-1:0]  node_ext;

  assign take_query = start_i && !busy_o && (operation_i == ksjt_pkg::OP_QUERY);
  assign take_load  = start_i && !busy_o && (operation_i == ksjt_pkg::OP_LOAD);
  assign node_ext   = ksjt_pkg::ENTRY_W'(node_i);

  // error status always comes with no node
  `ASSERT_SAME(a_err_no_node, clk_i, rst_ni,
    done_o && (status_o != ksjt_pkg::STATUS_OK), ancestor_o == ksjt_pkg::NO_NODE,
    "error status without no-node ancestor")

  // loads never produce a result
  `ASSERT_NEXT(a_load_silent, clk_i, rst_ni, take_load, !done_o,
    "result after a load item")

  // a result follows a query or a walk
  `ASSERT_SAME(a_done_cause, clk_i, rst_ni, done_o, $past(busy_o) || $past(take_query),
    "result without a query item")

  // zero steps on a built table returns the start node
  `ASSERT_NEXT(a_zero_step, clk_i, rst_ni, take_query && (step_count_i == '0),
    done_o && ((status_o != ksjt_pkg::STATUS_OK) || (ancestor_o == $past(node_ext))),
    "zero-step query did not return start node")

  // busy only starts on a taken item
  `ASSERT_SAME(a_busy_start, clk_i, rst_ni, $rose(busy_o), $past(start_i),
    "busy rose without an item")

endmodule

bind kth_successor_jump_table ksjt_checker u_ksjt_checker (.*);

`default_nettype wire
